// ===== rtl/core/polc_pkg.sv =====
`timescale 1ns / 1ps

package polc_pkg;

   localparam int MAX_PATTERN_DEFAULT   = 32;
   localparam int POSITION_BITS_DEFAULT = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int LENGTH_BITS    = 6;
   localparam int PATTERN_BYTES  = 32;
   localparam int PATTERN_BITS   = 8 * PATTERN_BYTES;

   localparam logic [7:0]  NEWLINE   = 8'd10;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [30:0] HALF_MAX  = 31'h7FFF_FFFF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH   = 3'd0,
      CSR_BYTES_0_7        = 3'd1,
      CSR_BYTES_8_15       = 3'd2,
      CSR_BYTES_16_23      = 3'd3,
      CSR_BYTES_24_31      = 3'd4,
      CSR_DOUBLE_BYTE_MODE = 3'd5
   } csr_index_type;

   typedef enum logic {
      KIND_OCCURRENCE = 1'b0,
      KIND_TOTAL      = 1'b1
   } report_kind_type;

   // Per-cell controls: load takes the shifted-in byte, clear empties the cell.
   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic found;
      logic end_of_text;
   } item_flags_type;

   // Pattern bytes beyond the register file read as zero.
   function automatic logic [7:0] pattern_byte(input logic [PATTERN_BITS-1:0] bits,
                                               input logic [6:0] idx);
      logic [7:0] b;
      b = 8'd0;
      if (idx < 7'(PATTERN_BYTES)) begin
         b = bits[idx[4:0]*8 +: 8];
      end
      return b;
   endfunction

endpackage

// ===== rtl/core/polc_cell.sv =====
`timescale 1ns / 1ps

module polc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  polc_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              shift_byte,
   input  logic [7:0]              pat_byte,
   input  logic                    active,
   output logic [7:0]              byte_out,
   output logic                    match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear) begin
         byte_in = 8'd0;
      end else if (ctrl.load) begin
         byte_in = shift_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   // The comparison looks at the byte this cell is about to hold, so the match
   // for the incoming word is known in the cycle it is accepted.
   assign match    = !active || (shift_byte == pat_byte);
   assign byte_out = byte_ff;

endmodule

// ===== rtl/core/polc_report.sv =====
`timescale 1ns / 1ps

module polc_report #(
   parameter int POSITION_BITS = polc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  polc_pkg::item_flags_type  flags,
   input  logic [POSITION_BITS-1:0]  start_pos,
   input  logic [POSITION_BITS-1:0]  newline_pos,
   input  logic [POSITION_BITS-1:0]  byte_count,
   input  logic [31:0]               lines,
   input  logic [31:0]               count,
   input  logic                      rsp_ready,
   output logic                      advance,
   output logic                      rsp_valid,
   output polc_pkg::report_kind_type rsp_kind,
   output logic [31:0]               rsp_count,
   output logic [31:0]               rsp_line,
   output logic [30:0]               rsp_column,
   output logic [30:0]               rsp_index,
   output logic                      rsp_last
);

   import polc_pkg::*;

   localparam int PB = POSITION_BITS;

   function automatic logic [30:0] half_sat(input logic [PB-1:0] v);
      logic [63:0] h;
      h = 64'(v >> 1);
      if (h > 64'(HALF_MAX)) begin
         h = 64'(HALF_MAX);
      end
      return h[30:0];
   endfunction

   // Middle stage
   logic           valid_ff, valid_in;
   item_flags_type flags_ff;
   logic [PB-1:0]  start_ff, newline_ff, total_ff;
   logic [31:0]    lines_ff, count_ff;

   // Output register: an occurrence and a total may wait together.
   logic        occ_valid_ff, occ_valid_in;
   logic        tot_valid_ff, tot_valid_in;
   logic [31:0] res_count_ff, res_line_ff;
   logic [30:0] occ_col_ff, occ_idx_ff, tot_idx_ff;

   logic          has_result, out_room, move, load_out;
   logic [PB-1:0] column_full;
   logic [31:0]   line_value;

   always_comb begin
      has_result = flags_ff.found || flags_ff.end_of_text;
      out_room   = (!occ_valid_ff && !tot_valid_ff) ||
                   (rsp_ready && !(occ_valid_ff && tot_valid_ff));
      move       = valid_ff && (!has_result || out_room);
      advance    = !valid_ff || move;
      load_out   = move && has_result;

      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (move) begin
         valid_in = 1'b0;
      end

      column_full = (start_ff >= newline_ff) ? (start_ff - newline_ff) : '0;
      line_value  = (lines_ff == COUNT_MAX) ? COUNT_MAX : (lines_ff + 32'd1);

      occ_valid_in = occ_valid_ff;
      tot_valid_in = tot_valid_ff;
      if (load_out) begin
         occ_valid_in = flags_ff.found;
         tot_valid_in = flags_ff.end_of_text;
      end else if (rsp_valid && rsp_ready) begin
         if (occ_valid_ff) begin
            occ_valid_in = 1'b0;
         end else begin
            tot_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         occ_valid_ff <= 1'b0;
         tot_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         occ_valid_ff <= occ_valid_in;
         tot_valid_ff <= tot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff   <= flags;
         start_ff   <= start_pos;
         newline_ff <= newline_pos;
         total_ff   <= byte_count;
         lines_ff   <= lines;
         count_ff   <= count;
      end
      if (load_out) begin
         res_count_ff <= count_ff;
         res_line_ff  <= line_value;
         occ_col_ff   <= half_sat(column_full);
         occ_idx_ff   <= half_sat(start_ff);
         tot_idx_ff   <= half_sat(total_ff);
      end
   end

   assign rsp_valid  = occ_valid_ff || tot_valid_ff;
   assign rsp_kind   = occ_valid_ff ? KIND_OCCURRENCE : KIND_TOTAL;
   assign rsp_count  = res_count_ff;
   assign rsp_line   = res_line_ff;
   assign rsp_column = occ_valid_ff ? occ_col_ff : 31'd0;
   assign rsp_index  = occ_valid_ff ? occ_idx_ff : tot_idx_ff;
   assign rsp_last   = !(occ_valid_ff && tot_valid_ff);

endmodule

// ===== rtl/core/pattern_occurrence_locator.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Word
// req_    | in        | tdata: text_byte[7:0]; tlast: end_of_text
// rsp_    | out       | tdata: count, line, column, char_index; tuser: kind; tlast: last
// csr_    | in        | write enable, register index, 64-bit write data
//
// One byte per cycle unless stalled; results pass the middle and output registers.
// The match test is a row of MAX_PATTERN byte cells feeding one AND tree, so the
// window shift, the compare and the skip counter all act in the cycle a byte is accepted.
// A match on the final byte puts an occurrence and a total into the output register.
// Reset is synchronous and clears the scan state and the registers to their defaults.
// A stalled result side stops acceptance only once both registers hold results.
module pattern_occurrence_locator #(
   parameter int MAX_PATTERN   = polc_pkg::MAX_PATTERN_DEFAULT,
   parameter int POSITION_BITS = polc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // text_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // occurrence_count[31:0], line_number[63:32], column[94:64], char_index[125:95]
   output logic [127:0]                       rsp_tdata,
   output logic                               rsp_tuser,   // report_kind
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [polc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [polc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import polc_pkg::*;

   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam int PB = POSITION_BITS;

   // Configuration registers
   logic [LENGTH_BITS-1:0]  length_ff, length_in;
   logic [PATTERN_BITS-1:0] pattern_ff, pattern_in;
   logic                    double_ff, double_in;

   always_comb begin
      length_in  = length_ff;
      pattern_in = pattern_ff;
      double_in  = double_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:   length_in          = csr_wdata[LENGTH_BITS-1:0];
            CSR_BYTES_0_7:        pattern_in[63:0]    = csr_wdata;
            CSR_BYTES_8_15:       pattern_in[127:64]  = csr_wdata;
            CSR_BYTES_16_23:      pattern_in[191:128] = csr_wdata;
            CSR_BYTES_24_31:      pattern_in[255:192] = csr_wdata;
            CSR_DOUBLE_BYTE_MODE: double_in          = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= LENGTH_BITS'(1);
         pattern_ff <= '0;
         double_ff  <= 1'b0;
      end else begin
         length_ff  <= length_in;
         pattern_ff <= pattern_in;
         double_ff  <= double_in;
      end
   end

   // Scan state
   logic [LW-1:0] fill_ff, fill_in;
   logic [LW-1:0] overlap_ff, overlap_in;
   logic          phase_ff, phase_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [PB-1:0] nlpos_ff, nlpos_in;
   logic [31:0]   lines_ff, lines_in;
   logic [31:0]   count_ff, count_in;

   logic                   accept, is_dropped, is_newline;
   logic [7:0]             text_byte;
   logic [LW-1:0]          len_eff, fill_next, len_m1;
   logic [7:0]             window [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_match;
   logic                   found_single, found_double, found;
   logic [PB-1:0]          pos_upd, nlpos_upd, start_pos;
   logic [31:0]            lines_upd, count_upd;
   logic                   advance;

   assign accept     = req_tvalid && req_tready;
   assign text_byte  = req_tdata;
   assign is_dropped = (text_byte != 8'd0) && !text_byte[7];
   assign is_newline = (text_byte == NEWLINE);

   always_comb begin
      if (7'(length_ff) > 7'(MAX_PATTERN)) begin
         len_eff = LW'(MAX_PATTERN);
      end else begin
         len_eff = LW'(length_ff);
      end
   end

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      cell_ctrl_type ctrl;
      logic [7:0]    shift_byte;
      logic [6:0]    pat_idx;

      if (k == 0) begin : g_head
         assign shift_byte = text_byte;
         // In double-byte mode the head cell keeps the first half of a pair.
         assign ctrl.load  = accept && (!double_ff || (!is_dropped && !phase_ff));
      end else begin : g_body
         assign shift_byte = window[k-1];
         assign ctrl.load  = accept && !double_ff;
      end
      assign ctrl.clear = accept && req_tlast;
      assign pat_idx    = 7'(len_eff) - 7'(k) - 7'd1;

      polc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .shift_byte (shift_byte),
         .pat_byte   (pattern_byte(pattern_ff, pat_idx)),
         .active     (LW'(k) < len_eff),
         .byte_out   (window[k]),
         .match      (cell_match[k])
      );
   end

   always_comb begin
      fill_next    = (fill_ff == LW'(MAX_PATTERN)) ? fill_ff : (fill_ff + LW'(1));
      found_single = (overlap_ff == '0) && (len_eff != '0) && (fill_next >= len_eff) &&
                     (&cell_match);
      found_double = !is_dropped && phase_ff && (window[0] == pattern_ff[7:0]) &&
                     (text_byte == pattern_ff[15:8]);
      found        = double_ff ? found_double : found_single;

      len_m1    = double_ff ? LW'(1) : (len_eff - LW'(1));
      start_pos = (pos_ff >= PB'(len_m1)) ? (pos_ff - PB'(len_m1)) : '0;

      pos_upd   = (pos_ff == '1) ? pos_ff : (pos_ff + PB'(1));
      lines_upd = lines_ff;
      nlpos_upd = nlpos_ff;
      if (is_newline) begin
         lines_upd = (lines_ff == COUNT_MAX) ? lines_ff : (lines_ff + 32'd1);
         nlpos_upd = pos_ff;
      end
      count_upd = count_ff;
      if (found && (count_ff != COUNT_MAX)) begin
         count_upd = count_ff + 32'd1;
      end

      fill_in    = fill_ff;
      overlap_in = overlap_ff;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      nlpos_in   = nlpos_ff;
      lines_in   = lines_ff;
      count_in   = count_ff;
      if (accept) begin
         if (double_ff) begin
            phase_in = is_dropped ? 1'b0 : !phase_ff;
         end else begin
            fill_in = fill_next;
            if (overlap_ff != '0) begin
               overlap_in = overlap_ff - LW'(1);
            end else if (found_single) begin
               overlap_in = len_eff - LW'(1);
            end
         end
         pos_in   = pos_upd;
         nlpos_in = nlpos_upd;
         lines_in = lines_upd;
         count_in = count_upd;
         // The end of a text returns every scan register to its idle value.
         if (req_tlast) begin
            fill_in    = '0;
            overlap_in = '0;
            phase_in   = 1'b0;
            pos_in     = '0;
            nlpos_in   = '0;
            lines_in   = '0;
            count_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         overlap_ff <= '0;
         phase_ff   <= 1'b0;
         pos_ff     <= '0;
         nlpos_ff   <= '0;
         lines_ff   <= '0;
         count_ff   <= '0;
      end else begin
         fill_ff    <= fill_in;
         overlap_ff <= overlap_in;
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         nlpos_ff   <= nlpos_in;
         lines_ff   <= lines_in;
         count_ff   <= count_in;
      end
   end

   item_flags_type  flags;
   report_kind_type rsp_kind;
   logic [31:0]     rsp_count, rsp_line;
   logic [30:0]     rsp_column, rsp_index;

   assign flags.found       = found;
   assign flags.end_of_text = req_tlast;

   polc_report #(
      .POSITION_BITS (POSITION_BITS)
   ) u_report (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .flags       (flags),
      .start_pos   (start_pos),
      .newline_pos (nlpos_upd),
      .byte_count  (pos_upd),
      .lines       (lines_upd),
      .count       (count_upd),
      .rsp_ready   (rsp_tready),
      .advance     (advance),
      .rsp_valid   (rsp_tvalid),
      .rsp_kind    (rsp_kind),
      .rsp_count   (rsp_count),
      .rsp_line    (rsp_line),
      .rsp_column  (rsp_column),
      .rsp_index   (rsp_index),
      .rsp_last    (rsp_tlast)
   );

   assign req_tready = advance;
   assign rsp_tuser  = rsp_kind;
   assign rsp_tdata  = {2'b00, rsp_index, rsp_column, rsp_line, rsp_count};

endmodule

// ===== verif/pattern_occurrence_locator_test.sv =====
`timescale 1ns / 1ps

module pattern_occurrence_locator_test;
   import polc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TOTAL_ITEMS    = 1120;

   typedef struct {
      report_kind_type kind;
      logic [31:0]     count;
      logic [31:0]     line;
      logic [30:0]     column;
      logic [30:0]     char_index;
      logic            last;
   } occurrence_report_type;

   class occurrence_scoreboard;
      logic [5:0]  pat_len;
      logic [63:0] pat_regs [4];
      logic        dbl_mode;

      logic [7:0]  window [32];
      int          fill;
      logic [31:0] byte_pos;
      logic [31:0] newlines;
      logic [31:0] last_nl;
      logic [31:0] match_total;
      int          overlap;
      logic        pair_phase;

      occurrence_report_type pending_reports [$];
      int errors;

      function new();
         pat_len  = 6'd1;
         dbl_mode = 1'b0;
         foreach (pat_regs[i]) pat_regs[i] = 64'd0;
         errors = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         foreach (window[i]) window[i] = 8'd0;
         fill        = 0;
         byte_pos    = 32'd0;
         newlines    = 32'd0;
         last_nl     = 32'd0;
         match_total = 32'd0;
         overlap     = 0;
         pair_phase  = 1'b0;
      endfunction

      function void apply_register(csr_index_type idx, logic [63:0] val);
         case (idx)
            CSR_PATTERN_LENGTH:   pat_len     = val[5:0];
            CSR_BYTES_0_7:        pat_regs[0] = val;
            CSR_BYTES_8_15:       pat_regs[1] = val;
            CSR_BYTES_16_23:      pat_regs[2] = val;
            CSR_BYTES_24_31:      pat_regs[3] = val;
            CSR_DOUBLE_BYTE_MODE: dbl_mode    = val[0];
            default: ;
         endcase
      endfunction

      function logic [7:0] pattern_at(int k);
         return pat_regs[k / 8][(k % 8) * 8 +: 8];
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      // Works out the reports that one accepted text word causes.
      function void scan_byte(logic [7:0] b, logic eot);
         logic [31:0]           cur;
         logic [31:0]           start;
         logic [31:0]           col;
         logic                  found;
         logic                  eq;
         int                    len;
         occurrence_report_type r;
         cur   = byte_pos;
         start = 32'd0;
         found = 1'b0;
         if (b == NEWLINE) begin
            if (newlines != COUNT_MAX) newlines++;
            last_nl = cur;
         end
         if (dbl_mode) begin
            if (b >= 8'd1 && b <= 8'd127) begin
               pair_phase = 1'b0;
            end else if (!pair_phase) begin
               window[0]  = b;
               pair_phase = 1'b1;
            end else begin
               pair_phase = 1'b0;
               if (window[0] == pattern_at(0) && b == pattern_at(1)) begin
                  found = 1'b1;
                  start = cur - 32'd1;
               end
            end
         end else begin
            len = (pat_len > 6'd32) ? 32 : int'(pat_len);
            for (int k = 31; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            if (fill < 32) fill++;
            if (overlap > 0) begin
               overlap--;
            end else if (len > 0 && fill >= len) begin
               eq = 1'b1;
               for (int k = 0; k < len; k++) begin
                  if (window[k] != pattern_at(len - 1 - k)) eq = 1'b0;
               end
               if (eq) begin
                  found   = 1'b1;
                  start   = (cur >= 32'(len - 1)) ? cur - 32'(len - 1) : 32'd0;
                  overlap = len - 1;
               end
            end
         end
         if (byte_pos != COUNT_MAX) byte_pos++;
         if (found) begin
            if (match_total != COUNT_MAX) match_total++;
            col          = (start >= last_nl) ? start - last_nl : 32'd0;
            r.kind       = KIND_OCCURRENCE;
            r.count      = match_total;
            r.line       = (newlines == COUNT_MAX) ? COUNT_MAX : newlines + 32'd1;
            r.column     = col[31:1];
            r.char_index = start[31:1];
            r.last       = !eot;
            pending_reports.push_back(r);
         end
         if (eot) begin
            r.kind       = KIND_TOTAL;
            r.count      = match_total;
            r.line       = (newlines == COUNT_MAX) ? COUNT_MAX : newlines + 32'd1;
            r.column     = 31'd0;
            r.char_index = byte_pos[31:1];
            r.last       = 1'b1;
            pending_reports.push_back(r);
            clear_scan();
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_report(occurrence_report_type got);
         occurrence_report_type want;
         if (pending_reports.size() == 0) begin
            report($sformatf("result with nothing expected, count %0d", got.count));
            return;
         end
         want = pending_reports.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.count !== want.count)
            report($sformatf("count %0d, expected %0d", got.count, want.count));
         if (got.line !== want.line)
            report($sformatf("line %0d, expected %0d", got.line, want.line));
         if (got.column !== want.column)
            report($sformatf("column %0d, expected %0d", got.column, want.column));
         if (got.char_index !== want.char_index)
            report($sformatf("char_index %0d, expected %0d", got.char_index,
                             want.char_index));
         if (got.last !== want.last)
            report($sformatf("last %0b, expected %0b", got.last, want.last));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic                      req_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [127:0]              rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   occurrence_scoreboard sb;
   int items_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   pattern_occurrence_locator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      occurrence_report_type got;
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = report_kind_type'(rsp_tuser);
            got.count      = rsp_tdata[31:0];
            got.line       = rsp_tdata[63:32];
            got.column     = rsp_tdata[94:64];
            got.char_index = rsp_tdata[125:95];
            got.last       = rsp_tlast;
            sb.check_report(got);
            quiet_cycles = 0;
         end
         if (req_tvalid && req_tready) begin
            sb.scan_byte(req_tdata, req_tlast);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(logic [7:0] b, logic eot);
      if (items_sent < TOTAL_ITEMS / 3) begin
         send_idle_pct = 34;
         recv_idle_pct = 53;
      end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
         send_idle_pct = 53;
         recv_idle_pct = 34;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   // Holds the sender back until every expected report has come out.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.apply_register(idx, val);
      @(negedge clock);
   endtask

   task automatic random_phase();
      logic [7:0]  pat [32];
      logic [7:0]  alpha [4];
      logic [63:0] regs [4];
      logic        dbl;
      int          len_cfg;
      int          len_eff;
      int          pick;
      int          n_items;
      int          j;
      int          bad;
      dbl  = ($urandom_range(99) < 20);
      pick = $urandom_range(99);
      if (pick < 50)      len_cfg = $urandom_range(1, 4);
      else if (pick < 75) len_cfg = $urandom_range(5, 12);
      else if (pick < 87) len_cfg = 32;
      else if (pick < 93) len_cfg = $urandom_range(33, 63);
      else if (pick < 96) len_cfg = 0;
      else                len_cfg = $urandom_range(13, 31);
      for (int k = 0; k < 4; k++) begin
         if (dbl) alpha[k] = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(128, 255));
         else     alpha[k] = 8'($urandom_range(255));
      end
      if (!dbl && $urandom_range(19) == 0) alpha[0] = NEWLINE;
      for (int k = 0; k < 32; k++) pat[k] = alpha[$urandom_range(3)];
      for (int i = 0; i < 4; i++) begin
         for (int k = 0; k < 8; k++) regs[i][k*8 +: 8] = pat[i*8 + k];
      end
      write_reg(CSR_PATTERN_LENGTH, 64'(len_cfg));
      write_reg(CSR_BYTES_0_7, regs[0]);
      write_reg(CSR_BYTES_8_15, regs[1]);
      write_reg(CSR_BYTES_16_23, regs[2]);
      write_reg(CSR_BYTES_24_31, regs[3]);
      write_reg(CSR_DOUBLE_BYTE_MODE, 64'(dbl));
      csr_we <= 1'b0;

      len_eff = dbl ? 2 : ((len_cfg > 32) ? 32 : len_cfg);
      n_items = $urandom_range(30, 90);
      j = 0;
      while (j < n_items) begin
         pick = $urandom_range(99);
         if (pick < 35 && len_eff > 0) begin
            // A copy of the pattern, now and then with one byte spoilt.
            bad = ($urandom_range(9) == 0) ? int'($urandom_range(len_eff - 1)) : -1;
            for (int k = 0; k < len_eff; k++) begin
               if (dbl && k == 1 && $urandom_range(6) == 0)
                  send_word(8'($urandom_range(1, 127)), 1'b0);
               send_word((k == bad) ? 8'($urandom) : pat[k], $urandom_range(199) == 0);
            end
            j += len_eff;
         end else if (pick < 85) begin
            if (dbl && $urandom_range(9) < 3)
               send_word(8'($urandom_range(1, 127)), $urandom_range(99) < 2);
            else if ($urandom_range(19) == 0)
               send_word(NEWLINE, $urandom_range(99) < 2);
            else
               send_word(alpha[$urandom_range(3)], $urandom_range(99) < 2);
            j++;
         end else begin
            send_word(8'($urandom_range(255)), $urandom_range(99) < 2);
            j++;
         end
      end
      if ($urandom_range(1) == 1) send_word(alpha[$urandom_range(3)], 1'b1);
      wait_idle();
   endtask

   initial begin
      sb            = new();
      items_sent    = 0;
      send_idle_pct = 34;
      recv_idle_pct = 53;
      quiet_cycles  = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'd0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_PATTERN_LENGTH;
      csr_wdata     = 64'd0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default pattern is a single zero byte.
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(NEWLINE, 1'b0);
      send_word(8'h00, 1'b1);
      wait_idle();

      // A zero length never matches.
      write_reg(CSR_PATTERN_LENGTH, 64'd0);
      csr_we <= 1'b0;
      send_word(8'h61, 1'b0);
      send_word(8'h61, 1'b1);
      wait_idle();

      // An oversized length is clipped to the full window.
      write_reg(CSR_PATTERN_LENGTH, 64'd63);
      write_reg(CSR_BYTES_0_7, {8{8'h61}});
      csr_we <= 1'b0;
      send_word(8'h61, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(8'h61, 1'b1);
      wait_idle();

      // Pattern that starts with a newline.
      write_reg(CSR_PATTERN_LENGTH, 64'd2);
      write_reg(CSR_BYTES_0_7, 64'h610A);
      csr_we <= 1'b0;
      send_word(8'h78, 1'b0);
      send_word(NEWLINE, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(NEWLINE, 1'b0);
      send_word(8'h61, 1'b1);
      wait_idle();

      // Double-byte character, with an ASCII byte breaking the first pair.
      write_reg(CSR_BYTES_0_7, 64'hC381);
      write_reg(CSR_DOUBLE_BYTE_MODE, 64'd1);
      csr_we <= 1'b0;
      send_word(8'h81, 1'b0);
      send_word(8'h41, 1'b0);
      send_word(8'h81, 1'b0);
      send_word(8'hC3, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hFF, 1'b1);
      wait_idle();

      while (items_sent < TOTAL_ITEMS) random_phase();

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/polc_pkg.sv
rtl/core/polc_cell.sv
rtl/core/polc_report.sv
rtl/core/pattern_occurrence_locator.sv
verif/pattern_occurrence_locator_test.sv
